// ===== rtl/core/xrg_pkg.sv =====
// ----------------------------------------------------------------------------
// xrg_pkg: shared definitions for the xoshiro random generator
// Operation codes, work kinds, fixed state words and the queue entry layout.
// ----------------------------------------------------------------------------
package xrg_pkg;

   localparam int OP_W        = 3;
   localparam int WORD_W      = 64;
   localparam int PROB_W      = 54;
   localparam int KIND_W      = 3;
   localparam int STATE_WORDS = 4;
   localparam int FRAC_SHIFT  = 11;

   localparam logic [OP_W-1:0] OP_RAW       = 3'd0;
   localparam logic [OP_W-1:0] OP_FRACTION  = 3'd1;
   localparam logic [OP_W-1:0] OP_RANGE     = 3'd2;
   localparam logic [OP_W-1:0] OP_BERNOULLI = 3'd3;
   localparam logic [OP_W-1:0] OP_RESEED    = 3'd4;

   localparam logic [KIND_W-1:0] KIND_RAW       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FRACTION  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RANGE     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BERNOULLI = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESEED    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd5;

   localparam logic [WORD_W-1:0] RESET_WORD0  = 64'h180E_C6D3_3CFD_0ABA;
   localparam logic [WORD_W-1:0] RESET_WORD1  = 64'hD5A6_1266_F0C9_392C;
   localparam logic [WORD_W-1:0] RESET_WORD2  = 64'hA958_2618_E03F_C9AA;
   localparam logic [WORD_W-1:0] RESET_WORD3  = 64'h39AB_DC45_29B1_661C;
   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL1     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL2     = 64'h94D0_49BB_1331_11EB;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      word_type          operand;
      word_type          diff;
      logic              full_span;
      logic [PROB_W-1:0] probability;
   } entry_type;

endpackage

// ===== rtl/core/xrg_channels.sv =====
// ----------------------------------------------------------------------------
// xrg_channels: request and response channels of the random generator
// Each channel carries valid, ready and its payload, with source and sink views.
// ----------------------------------------------------------------------------
interface xrg_req_if import xrg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [WORD_W-1:0]        seed_value;
   logic signed [WORD_W-1:0] range_low;
   logic signed [WORD_W-1:0] range_high;
   logic [PROB_W-1:0]        probability;

   modport source (output valid, operation, seed_value, range_low, range_high, probability,
                   input ready);
   modport sink (input valid, operation, seed_value, range_low, range_high, probability,
                 output ready);
endinterface

interface xrg_rsp_if import xrg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;

   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

// ===== rtl/core/xrg_front.sv =====
// ----------------------------------------------------------------------------
// xrg_front: request intake and classification
// Decodes the operation, prepares the range span and pushes work into the queue.
// ----------------------------------------------------------------------------
module xrg_front import xrg_pkg::*; (
   xrg_req_if.sink   req,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   logic known;
   logic empty_range;

   assign req.ready = !queue_full;

   always_comb begin
      empty_range            = req.range_high <= req.range_low;
      push_entry.diff        = unsigned'(req.range_high - req.range_low);
      push_entry.full_span   = &push_entry.diff;
      push_entry.probability = req.probability;
      push_entry.operand     = (req.operation == OP_RESEED) ? req.seed_value
                                                            : unsigned'(req.range_low);
      known                  = 1'b1;
      unique case (req.operation)
         OP_RAW: begin
            push_entry.kind = KIND_RAW;
         end
         OP_FRACTION: begin
            push_entry.kind = KIND_FRACTION;
         end
         OP_RANGE: begin
            push_entry.kind = empty_range ? KIND_EMPTY : KIND_RANGE;
         end
         OP_BERNOULLI: begin
            push_entry.kind = KIND_BERNOULLI;
         end
         OP_RESEED: begin
            push_entry.kind = KIND_RESEED;
         end
         default: begin
            push_entry.kind = KIND_RAW;
            known           = 1'b0;
         end
      endcase
      push = req.valid && req.ready && known;
   end

endmodule

// ===== rtl/core/xrg_queue.sv =====
// ----------------------------------------------------------------------------
// xrg_queue: short work queue between intake and execution
// A small circular buffer that lets the intake and the execution stall apart.
// ----------------------------------------------------------------------------
module xrg_queue import xrg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] ptr);
      return (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/xrg_back.sv =====
// ----------------------------------------------------------------------------
// xrg_back: generator state and operation sequencer
// Holds the xoshiro256** words, runs draws, the bit-serial range remainder,
// the SplitMix64 reseed on a shared 32x32 multiplier, and the result register.
// ----------------------------------------------------------------------------
module xrg_back import xrg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      queue_empty,
   output logic      pop,
   xrg_rsp_if.source rsp
);

   localparam int STATE_W   = 4;
   localparam int DIV_CNT_W = $clog2(WORD_W);
   localparam int HALF_W    = WORD_W / 2;
   localparam int ROUND_W   = $clog2(STATE_WORDS);

   localparam logic [STATE_W-1:0] S_IDLE      = 4'd0;
   localparam logic [STATE_W-1:0] S_DRAW      = 4'd1;
   localparam logic [STATE_W-1:0] S_OUT       = 4'd2;
   localparam logic [STATE_W-1:0] S_DIV       = 4'd3;
   localparam logic [STATE_W-1:0] S_ADD       = 4'd4;
   localparam logic [STATE_W-1:0] S_RES       = 4'd5;
   localparam logic [STATE_W-1:0] S_FINISH    = 4'd6;
   localparam logic [STATE_W-1:0] S_SEED_ADD  = 4'd7;
   localparam logic [STATE_W-1:0] S_SEED_MIX  = 4'd8;
   localparam logic [STATE_W-1:0] S_SEED_MUL  = 4'd9;
   localparam logic [STATE_W-1:0] S_SEED_WORD = 4'd10;

   localparam logic [1:0] MSTEP_LOW   = 2'd0;
   localparam logic [1:0] MSTEP_CROSS = 2'd1;
   localparam logic [1:0] MSTEP_SWAP  = 2'd2;
   localparam logic [1:0] MSTEP_LAST  = 2'd3;

   logic [STATE_W-1:0]   state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   word_type             operand_ff, operand_in;
   logic                 full_ff, full_in;
   logic [PROB_W-1:0]    prob_ff, prob_in;
   word_type             span_ff, span_in;
   word_type             s_ff [STATE_WORDS];
   word_type             s_in [STATE_WORDS];
   word_type             t_ff, t_in;
   word_type             x_ff, x_in;
   word_type             rem_ff, rem_in;
   word_type             res_ff, res_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   word_type             z_ff, z_in;
   word_type             mul_a_ff, mul_a_in;
   word_type             acc_ff, acc_in;
   word_type             prod_ff, prod_in;
   logic [1:0]           mstep_ff, mstep_in;
   logic                 mul_sel_ff, mul_sel_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_value_ff, rsp_value_in;

   word_type          times5;
   word_type          new0, new1, new2, new3;
   word_type          x9;
   logic [WORD_W:0]   trial, trial_diff;
   word_type          rem_next;
   word_type          mul_b;
   logic [HALF_W-1:0] mul_x, mul_y;
   word_type          cross_sum;
   logic              out_free;

   function automatic word_type rotl(input word_type v, input int unsigned amt);
      return (v << amt) | (v >> (WORD_W - amt));
   endfunction

   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = rsp_value_ff;

   always_comb begin
      times5     = s_ff[1] + (s_ff[1] << 2);
      new2       = s_ff[2] ^ s_ff[0];
      new3       = s_ff[3] ^ s_ff[1];
      new1       = s_ff[1] ^ new2;
      new0       = s_ff[0] ^ new3;
      new2       = new2 ^ (s_ff[1] << 17);
      new3       = rotl(new3, 45);
      x9         = t_ff + (t_ff << 3);
      trial      = {rem_ff, x_ff[WORD_W-1]};
      trial_diff = trial - {1'b0, span_ff};
      rem_next   = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];
      mul_b      = mul_sel_ff ? MIX_MUL2 : MIX_MUL1;
      case (mstep_ff)
         MSTEP_LOW: begin
            mul_x = mul_a_ff[HALF_W-1:0];
            mul_y = mul_b[HALF_W-1:0];
         end
         MSTEP_CROSS: begin
            mul_x = mul_a_ff[HALF_W-1:0];
            mul_y = mul_b[WORD_W-1:HALF_W];
         end
         default: begin
            mul_x = mul_a_ff[WORD_W-1:HALF_W];
            mul_y = mul_b[HALF_W-1:0];
         end
      endcase
      cross_sum = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
      out_free  = !rsp_valid_ff || rsp.ready;

      pop          = 1'b0;
      state_in     = state_ff;
      kind_in      = kind_ff;
      operand_in   = operand_ff;
      full_in      = full_ff;
      prob_in      = prob_ff;
      span_in      = span_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      div_cnt_in   = div_cnt_ff;
      z_in         = z_ff;
      mul_a_in     = mul_a_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mstep_in     = mstep_ff;
      mul_sel_in   = mul_sel_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop        = 1'b1;
               kind_in    = head.kind;
               operand_in = head.operand;
               full_in    = head.full_span;
               prob_in    = head.probability;
               span_in    = head.diff + 1'b1;
               z_in       = head.operand;
               round_in   = '0;
               mul_sel_in = 1'b0;
               case (head.kind)
                  KIND_RESEED: begin
                     state_in = S_SEED_ADD;
                  end
                  KIND_EMPTY: begin
                     res_in   = head.operand;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_DRAW;
                  end
               endcase
            end
         end
         S_DRAW: begin
            t_in     = rotl(times5, 7);
            s_in[0]  = new0;
            s_in[1]  = new1;
            s_in[2]  = new2;
            s_in[3]  = new3;
            state_in = S_OUT;
         end
         S_OUT: begin
            x_in       = x9;
            rem_in     = '0;
            div_cnt_in = '0;
            if (kind_ff == KIND_RANGE) begin
               state_in = full_ff ? S_ADD : S_DIV;
            end else begin
               state_in = S_RES;
            end
         end
         S_DIV: begin
            rem_in     = rem_next;
            x_in       = x_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            res_in   = operand_ff + (full_ff ? x_ff : rem_ff);
            state_in = S_FINISH;
         end
         S_RES: begin
            case (kind_ff)
               KIND_RAW: begin
                  res_in = x_ff;
               end
               KIND_FRACTION: begin
                  res_in = x_ff >> FRAC_SHIFT;
               end
               default: begin
                  res_in = word_type'((x_ff >> FRAC_SHIFT) < word_type'(prob_ff));
               end
            endcase
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         S_SEED_ADD: begin
            z_in     = z_ff + GOLDEN_GAMMA;
            state_in = S_SEED_MIX;
         end
         S_SEED_MIX: begin
            mul_a_in = mul_sel_ff ? (z_ff ^ (z_ff >> 27)) : (z_ff ^ (z_ff >> 30));
            mstep_in = MSTEP_LOW;
            state_in = S_SEED_MUL;
         end
         S_SEED_MUL: begin
            prod_in  = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
            mstep_in = mstep_ff + 1'b1;
            case (mstep_ff)
               MSTEP_CROSS: begin
                  acc_in = prod_ff;
               end
               MSTEP_SWAP: begin
                  acc_in = cross_sum;
               end
               MSTEP_LAST: begin
                  z_in = cross_sum;
                  if (mul_sel_ff) begin
                     state_in = S_SEED_WORD;
                  end else begin
                     mul_sel_in = 1'b1;
                     state_in   = S_SEED_MIX;
                  end
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
         S_SEED_WORD: begin
            s_in[round_ff] = z_ff ^ (z_ff >> 31);
            round_in       = round_ff + 1'b1;
            mul_sel_in     = 1'b0;
            if (round_ff == ROUND_W'(STATE_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SEED_ADD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         mstep_ff     <= MSTEP_LOW;
         mul_sel_ff   <= 1'b0;
         round_ff     <= '0;
         s_ff[0]      <= RESET_WORD0;
         s_ff[1]      <= RESET_WORD1;
         s_ff[2]      <= RESET_WORD2;
         s_ff[3]      <= RESET_WORD3;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
         mstep_ff     <= mstep_in;
         mul_sel_ff   <= mul_sel_in;
         round_ff     <= round_in;
         s_ff         <= s_in;
      end
      kind_ff      <= kind_in;
      operand_ff   <= operand_in;
      full_ff      <= full_in;
      prob_ff      <= prob_in;
      span_ff      <= span_in;
      t_ff         <= t_in;
      x_ff         <= x_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      z_ff         <= z_in;
      mul_a_ff     <= mul_a_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

// ===== rtl/core/xoshiro_random_generator.sv =====
// ----------------------------------------------------------------------------
// xoshiro_random_generator: xoshiro256** generator with SplitMix64 reseeding
// Requests arrive on req_bus as valid/ready transactions that name one operation:
// raw, fraction, integer range, Bernoulli trial or reseed. Each operation except
// reseed returns one transaction on rsp_bus; reseed and unused codes return none.
// An accepted request waits in a two-entry queue, so the request side keeps
// taking transactions while a result is held in the output register.
// Work in the execution sequencer, starting from the queue head:
//   raw, fraction and Bernoulli pass through pop, the draw states, result and output,
//   an empty range goes from pop straight to output,
//   a range runs the bit-serial 64-step remainder loop after the draw,
//   a full 64-bit span range skips that remainder loop,
//   a reseed runs eight 64-bit multiplies on one shared
//   32x32 multiplier, each in the steps low, cross, swap and last.
// Reset clears the queue and the output register and loads the four default
// state words. When the receiver stalls, the result stays in the output
// register and the sequencer waits.
// ----------------------------------------------------------------------------
module xoshiro_random_generator import xrg_pkg::*; (
   input logic       clock,
   input logic       reset,
   xrg_req_if.sink   req_bus,
   xrg_rsp_if.source rsp_bus
);

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      queue_full;
   logic      pop;
   logic      queue_empty;

   xrg_front u_front (
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   xrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   xrg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

// ===== rtl/core/xrg_checker.sv =====
// ----------------------------------------------------------------------------
// xrg_checker: port-level checks for the random generator
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module xrg_checker import xrg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_value
);

   a_reset_clears : assert property (@(posedge clock) reset |=> (!rsp_valid && req_ready))
      else $error("Reset did not empty the queue and the output register.");

   a_reset_latency : assert property (@(posedge clock) reset |-> ##2 !rsp_valid)
      else $error("A response appeared sooner after reset than the pipeline allows.");

   a_ready_falls : assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready))
      else $error("The queue filled without an accepted transaction.");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("A stalled response changed or was dropped.");

endmodule

bind xoshiro_random_generator xrg_checker u_xrg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.value)
);
